FILE: hw/rtl/rcpa_pkg.sv
// shared types and constants of the reference-counted page allocator
package rcpa_pkg;

  localparam int PAGE_W     = 12;  // page index and base page fields
  localparam int NPAGE_W    = 13;  // page count fields and unused page count
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_NOMEM = 3'd1,
    ST_RANGE = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_INC   = 2'd1,
    CMD_DEC   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_FIRST = 2'd0,
    CFG_R0_COUNT = 2'd1,
    CFG_R1_FIRST = 2'd2,
    CFG_R1_COUNT = 2'd3
  } cfg_idx_t;

endpackage

FILE: hw/rtl/rcpa_ram.sv
// generic single write port, single read port ram with registered read
module rcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/refcounted_page_allocator.sv
// reference-counted page allocator: count store, first-fit scan and range update
//
//  channel   ports                                          transaction
//  command   start, busy, in_cmd, in_page_index,            start high while busy low
//            in_page_count
//  result    out_valid, out_status, out_base_page,          out_valid high for one cycle
//            out_phys_addr, out_unused_pages
//  config    cfg_we, cfg_idx, cfg_wdata                     cfg_we high
//
// one command at a time; every count read and write goes through the single ram port pair.
// allocate: one page a cycle over region 0 then region 1, then the found run is filled.
// increment/decrement: a check pass and then an update pass; an overflow or underflow ends
// after the check pass. the result shows the cycle after the last of these.
// rejected and zero-length commands answer the next cycle.
// after reset a clearing pass over every page keeps busy high; config is taken meanwhile.
// the result is shown for one cycle only; the receiver cannot stall it.
module refcounted_page_allocator #(
  parameter int           STORE_PAGES = 4096,
  parameter int           PAGE_SHIFT  = 12,
  parameter logic [47:0]  MEM_BASE    = 48'd16777216,
  parameter int           COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [rcpa_pkg::PAGE_W-1:0]         in_page_index,
  input  logic [rcpa_pkg::NPAGE_W-1:0]        in_page_count,
  // result
  output logic                                out_valid,
  output logic [rcpa_pkg::STATUS_W-1:0]       out_status,
  output logic [rcpa_pkg::PAGE_W-1:0]         out_base_page,
  output logic [rcpa_pkg::ADDR_W-1:0]         out_phys_addr,
  output logic [rcpa_pkg::NPAGE_W-1:0]        out_unused_pages,
  // configuration
  input  logic                                cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rcpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PW    = $clog2(STORE_PAGES);
  localparam int PTR_W = (PW + 1 > 14) ? PW + 1 : 14;
  localparam int FW    = $clog2(STORE_PAGES + 1);
  localparam logic [PTR_W-1:0] NP = PTR_W'(STORE_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_MODIFY,
    S_FILL
  } state_t;

  state_t                          state_r, state_nxt;
  logic [PTR_W-1:0]                ptr_r, ptr_nxt;
  logic [PTR_W-1:0]                end_r, end_nxt;
  logic [PTR_W-1:0]                run_r, run_nxt;
  logic [PTR_W-1:0]                base_r, base_nxt;
  logic [PTR_W-1:0]                first_r, first_nxt;
  logic [PTR_W-1:0]                n_r, n_nxt;
  logic [PTR_W-1:0]                rd_page_r, rd_page_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic                            region_r, region_nxt;
  logic                            inc_r, inc_nxt;
  logic                            err_r, err_nxt;
  logic [FW-1:0]                   free_r, free_nxt;

  logic [rcpa_pkg::PAGE_W-1:0]     r0_first_r, r0_first_nxt;
  logic [rcpa_pkg::NPAGE_W-1:0]    r0_count_r, r0_count_nxt;
  logic [rcpa_pkg::PAGE_W-1:0]     r1_first_r, r1_first_nxt;
  logic [rcpa_pkg::NPAGE_W-1:0]    r1_count_r, r1_count_nxt;

  logic                            out_valid_r, out_valid_nxt;
  rcpa_pkg::status_t               out_status_r, out_status_nxt;
  logic [rcpa_pkg::PAGE_W-1:0]     out_base_r, out_base_nxt;
  logic [rcpa_pkg::ADDR_W-1:0]     out_phys_r, out_phys_nxt;
  logic [rcpa_pkg::NPAGE_W-1:0]    out_unused_r, out_unused_nxt;

  logic                            mem_we, mem_re;
  logic [PW-1:0]                   mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0]           mem_wdata, mem_rdata;

  logic [PTR_W-1:0]                reg_first_sel, reg_count_sel, reg_sum, reg_end_sel;
  logic [PTR_W-1:0]                in_first_ext, in_n_ext, in_sum;
  logic [PTR_W-1:0]                found_base;
  logic                            issue;

  rcpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (STORE_PAGES)
  ) u_counts (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // region bounds, cut at the end of the store; region 1 is used only once a scan is running
  always_comb begin
    reg_first_sel = (state_r == S_SCAN) ? PTR_W'(r1_first_r) : PTR_W'(r0_first_r);
    reg_count_sel = (state_r == S_SCAN) ? PTR_W'(r1_count_r) : PTR_W'(r0_count_r);
    reg_sum       = reg_first_sel + reg_count_sel;
    reg_end_sel   = (reg_sum > NP) ? NP : reg_sum;
  end

  assign in_first_ext = PTR_W'(in_page_index);
  assign in_n_ext     = PTR_W'(in_page_count);
  assign in_sum       = in_first_ext + in_n_ext;
  assign found_base   = rd_page_r + PTR_W'(1) - n_r;
  assign issue        = (ptr_r < end_r);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    run_nxt        = run_r;
    base_nxt       = base_r;
    first_nxt      = first_r;
    n_nxt          = n_r;
    rd_page_nxt    = rd_page_r;
    rd_vld_nxt     = rd_vld_r;
    region_nxt     = region_r;
    inc_nxt        = inc_r;
    err_nxt        = err_r;
    free_nxt       = free_r;
    r0_first_nxt   = r0_first_r;
    r0_count_nxt   = r0_count_r;
    r1_first_nxt   = r1_first_r;
    r1_count_nxt   = r1_count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_phys_nxt   = out_phys_r;
    out_unused_nxt = out_unused_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[PW-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r[PW-1:0];

    if (cfg_we) begin
      case (rcpa_pkg::cfg_idx_t'(cfg_idx))
        rcpa_pkg::CFG_R0_FIRST: r0_first_nxt = cfg_wdata[rcpa_pkg::PAGE_W-1:0];
        rcpa_pkg::CFG_R0_COUNT: r0_count_nxt = cfg_wdata;
        rcpa_pkg::CFG_R1_FIRST: r1_first_nxt = cfg_wdata[rcpa_pkg::PAGE_W-1:0];
        rcpa_pkg::CFG_R1_COUNT: r1_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + PTR_W'(1);
        if (ptr_r == NP - PTR_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          out_base_nxt = '0;
          out_phys_nxt = '0;
          rd_vld_nxt   = 1'b0;
          case (rcpa_pkg::cmd_t'(in_cmd))
            rcpa_pkg::CMD_ALLOC: begin
              if (in_page_count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = rcpa_pkg::ST_RANGE;
              end else begin
                state_nxt  = S_SCAN;
                ptr_nxt    = reg_first_sel;
                end_nxt    = reg_end_sel;
                run_nxt    = '0;
                region_nxt = 1'b0;
                n_nxt      = in_n_ext;
              end
            end
            rcpa_pkg::CMD_INC, rcpa_pkg::CMD_DEC: begin
              if (in_sum > NP) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = rcpa_pkg::ST_RANGE;
              end else if (in_page_count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = rcpa_pkg::ST_OK;
              end else begin
                state_nxt = S_CHECK;
                ptr_nxt   = in_first_ext;
                end_nxt   = in_sum;
                first_nxt = in_first_ext;
                inc_nxt   = (rcpa_pkg::cmd_t'(in_cmd) == rcpa_pkg::CMD_INC);
                err_nxt   = 1'b0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = rcpa_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_re      = issue;
        rd_vld_nxt  = issue;
        rd_page_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (rd_vld_r) begin
          if (mem_rdata != '0) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_r + PTR_W'(1);
            if (run_r + PTR_W'(1) == n_r) begin
              state_nxt  = S_FILL;
              ptr_nxt    = found_base;
              base_nxt   = found_base;
              end_nxt    = found_base + n_r;
              rd_vld_nxt = 1'b0;
            end
          end
        end else if (!issue) begin
          if (!region_r) begin
            // region 0 exhausted, go on with region 1
            region_nxt = 1'b1;
            ptr_nxt    = reg_first_sel;
            end_nxt    = reg_end_sel;
            run_nxt    = '0;
          end else begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = rcpa_pkg::ST_NOMEM;
          end
        end
      end

      S_FILL: begin
        // every page of a found run is free, so its new count is one
        mem_we    = 1'b1;
        mem_wdata = COUNT_BITS'(1);
        ptr_nxt   = ptr_r + PTR_W'(1);
        free_nxt  = free_r - FW'(1);
        if (ptr_r + PTR_W'(1) == end_r) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = rcpa_pkg::ST_OK;
          out_base_nxt   = base_r[rcpa_pkg::PAGE_W-1:0];
          out_phys_nxt   = MEM_BASE + (rcpa_pkg::ADDR_W'(base_r) << PAGE_SHIFT);
        end
      end

      S_CHECK: begin
        mem_re      = issue;
        rd_vld_nxt  = issue;
        rd_page_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (rd_vld_r) begin
          if (inc_r ? (mem_rdata == '1) : (mem_rdata == '0)) begin
            err_nxt = 1'b1;
          end
        end else if (!issue) begin
          if (err_r) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = inc_r ? rcpa_pkg::ST_OVER : rcpa_pkg::ST_UNDER;
          end else begin
            state_nxt = S_MODIFY;
            ptr_nxt   = first_r;
          end
        end
      end

      S_MODIFY: begin
        // read page i while page i-1 is written back, never the same entry
        mem_re      = issue;
        rd_vld_nxt  = issue;
        rd_page_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_page_r[PW-1:0];
          if (inc_r) begin
            mem_wdata = mem_rdata + COUNT_BITS'(1);
            if (mem_rdata == '0) begin
              free_nxt = free_r - FW'(1);
            end
          end else begin
            mem_wdata = mem_rdata - COUNT_BITS'(1);
            if (mem_rdata == COUNT_BITS'(1)) begin
              free_nxt = free_r + FW'(1);
            end
          end
        end else if (!issue) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = rcpa_pkg::ST_OK;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (out_valid_nxt) begin
      out_unused_nxt = rcpa_pkg::NPAGE_W'(free_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ptr_r        <= '0;
      end_r        <= '0;
      run_r        <= '0;
      base_r       <= '0;
      first_r      <= '0;
      n_r          <= '0;
      rd_page_r    <= '0;
      rd_vld_r     <= 1'b0;
      region_r     <= 1'b0;
      inc_r        <= 1'b0;
      err_r        <= 1'b0;
      free_r       <= FW'(STORE_PAGES);
      r0_first_r   <= '0;
      r0_count_r   <= rcpa_pkg::NPAGE_W'(4096);
      r1_first_r   <= '0;
      r1_count_r   <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= rcpa_pkg::ST_OK;
      out_base_r   <= '0;
      out_phys_r   <= '0;
      out_unused_r <= '0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      end_r        <= end_nxt;
      run_r        <= run_nxt;
      base_r       <= base_nxt;
      first_r      <= first_nxt;
      n_r          <= n_nxt;
      rd_page_r    <= rd_page_nxt;
      rd_vld_r     <= rd_vld_nxt;
      region_r     <= region_nxt;
      inc_r        <= inc_nxt;
      err_r        <= err_nxt;
      free_r       <= free_nxt;
      r0_first_r   <= r0_first_nxt;
      r0_count_r   <= r0_count_nxt;
      r1_first_r   <= r1_first_nxt;
      r1_count_r   <= r1_count_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_base_r   <= out_base_nxt;
      out_phys_r   <= out_phys_nxt;
      out_unused_r <= out_unused_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_base_page    = out_base_r;
  assign out_phys_addr    = out_phys_r;
  assign out_unused_pages = out_unused_r;

  // no transaction is answered while the store is still being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !out_valid_r)
    else $error("result raised during clearing pass");

  // the count store is only written while a command or the clearing pass is running
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> busy)
    else $error("count store written while idle");

  // the free page count can never exceed the store size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FW'(STORE_PAGES))
    else $error("free page count above store size");

  // only a successful allocation carries a base page and an address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != rcpa_pkg::ST_OK) |->
      (out_base_r == '0 && out_phys_r == '0))
    else $error("failed command returned a base page or address");

endmodule

FILE: sim/refcounted_page_allocator_tb.sv
// self-checking testbench for the reference-counted page allocator
module refcounted_page_allocator_tb;
  import rcpa_pkg::*;

  localparam int          STORE_PAGES = 4096;
  localparam int          PAGE_SHIFT  = 12;
  localparam logic [47:0] MEM_BASE    = 48'd16777216;
  localparam int          COUNT_BITS  = 16;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [COUNT_BITS-1:0] REF_MAX = '1;
  localparam int          PHASE_ITEMS = 29;

  typedef struct packed {
    status_t              status;
    logic [PAGE_W-1:0]    base;
    logic [ADDR_W-1:0]    addr;
    logic [NPAGE_W-1:0]   unused;
  } page_result_t;

  typedef struct {
    bit                   is_reg;
    cfg_idx_t             reg_idx;
    logic [NPAGE_W-1:0]   reg_val;
    logic [1:0]           cmd;
    logic [PAGE_W-1:0]    idx;
    logic [NPAGE_W-1:0]   n;
    bit                   typed;
    page_result_t         want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_cmd;
  logic [PAGE_W-1:0]       in_page_index;
  logic [NPAGE_W-1:0]      in_page_count;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [PAGE_W-1:0]       out_base_page;
  logic [ADDR_W-1:0]       out_phys_addr;
  logic [NPAGE_W-1:0]      out_unused_pages;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  // shadow of the count store, the free page count and the region registers
  logic [COUNT_BITS-1:0]   page_refs [STORE_PAGES];
  logic [NPAGE_W-1:0]      free_pages;
  logic [PAGE_W-1:0]       region_first [2];
  logic [NPAGE_W-1:0]      region_len [2];

  page_result_t            pending [$];
  int                      live_base [$];
  int                      live_len [$];
  bit                      row_typed;
  page_result_t            row_want;
  int                      idle_pct;
  int                      errors;
  plan_row_t               plan [$];

  refcounted_page_allocator #(
    .STORE_PAGES(STORE_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT),
    .MEM_BASE(MEM_BASE),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void take_refs(int first, int cnt);
    int p;
    for (p = first; p < first + cnt; p++) begin
      if (page_refs[p] == 0) free_pages--;
      page_refs[p]++;
    end
  endfunction

  function automatic page_result_t apply_command(logic [1:0] c, logic [PAGE_W-1:0] idx,
                                                 logic [NPAGE_W-1:0] n);
    page_result_t res;
    int lo, hi, run, p, r;
    bit found;
    res.status = ST_OK;
    res.base = '0;
    res.addr = '0;
    found = 1'b0;
    case (c)
      CMD_ALLOC: begin
        if (n == 0) begin
          res.status = ST_RANGE;
        end else begin
          // first fit: region 0, then region 1, each cut at the end of the store
          for (r = 0; r < 2 && !found; r++) begin
            lo = int'(region_first[r]);
            hi = lo + int'(region_len[r]);
            if (hi > STORE_PAGES) hi = STORE_PAGES;
            run = 0;
            for (p = lo; p < hi && !found; p++) begin
              if (page_refs[p] != 0) begin
                run = 0;
              end else begin
                run++;
                if (run == int'(n)) begin
                  found = 1'b1;
                  res.base = PAGE_W'(p + 1 - int'(n));
                end
              end
            end
          end
          if (found) begin
            take_refs(int'(res.base), int'(n));
            res.addr = MEM_BASE + (ADDR_W'(res.base) << PAGE_SHIFT);
          end else begin
            res.status = ST_NOMEM;
          end
        end
      end
      CMD_INC: begin
        if (int'(idx) + int'(n) > STORE_PAGES) begin
          res.status = ST_RANGE;
        end else begin
          for (p = int'(idx); p < int'(idx) + int'(n); p++)
            if (page_refs[p] == REF_MAX) res.status = ST_OVER;
          if (res.status == ST_OK) take_refs(int'(idx), int'(n));
        end
      end
      CMD_DEC: begin
        if (int'(idx) + int'(n) > STORE_PAGES) begin
          res.status = ST_RANGE;
        end else begin
          for (p = int'(idx); p < int'(idx) + int'(n); p++)
            if (page_refs[p] == 0) res.status = ST_UNDER;
          if (res.status == ST_OK) begin
            for (p = int'(idx); p < int'(idx) + int'(n); p++) begin
              page_refs[p]--;
              if (page_refs[p] == 0) free_pages++;
            end
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.unused = free_pages;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // results are checked before a transaction on the same edge is predicted
  always @(posedge clk) begin
    page_result_t want, predicted;
    if (rst_n) begin
      if (out_valid) begin
        if (pending.size() == 0) begin
          flag_mismatch("result with nothing pending, status", out_status, 0);
        end else begin
          want = pending.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", out_status, want.status);
          if (out_base_page !== want.base)
            flag_mismatch("base_page", out_base_page, want.base);
          if (out_phys_addr !== want.addr)
            flag_mismatch("phys_addr", out_phys_addr, want.addr);
          if (out_unused_pages !== want.unused)
            flag_mismatch("unused_pages", out_unused_pages, want.unused);
        end
      end
      if (start && !busy) begin
        predicted = apply_command(in_cmd, in_page_index, in_page_count);
        if (in_cmd == CMD_ALLOC && predicted.status == ST_OK) begin
          live_base.push_back(int'(predicted.base));
          live_len.push_back(int'(in_page_count));
          if (live_base.size() > 24) begin
            void'(live_base.pop_front());
            void'(live_len.pop_front());
          end
        end
        pending.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  task automatic issue_command(logic [1:0] c, logic [PAGE_W-1:0] idx, logic [NPAGE_W-1:0] n,
                               bit typed, page_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_cmd = c;
    in_page_index = idx;
    in_page_count = n;
    row_typed = typed;
    row_want = want;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, logic [NPAGE_W-1:0] v);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_wdata = v;
    case (r)
      CFG_R0_FIRST: region_first[0] = v[PAGE_W-1:0];
      CFG_R0_COUNT: region_len[0] = v;
      CFG_R1_FIRST: region_first[1] = v[PAGE_W-1:0];
      CFG_R1_COUNT: region_len[1] = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic plan_row_t cmd_row(logic [1:0] c, int idx, int n);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.cmd = c;
    row.idx = PAGE_W'(idx);
    row.n = NPAGE_W'(n);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [1:0] c, int idx, int n, status_t st,
                                            int base, logic [47:0] addr, int unused);
    plan_row_t row;
    row = cmd_row(c, idx, n);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.base = PAGE_W'(base);
    row.want.addr = addr;
    row.want.unused = NPAGE_W'(unused);
    return row;
  endfunction

  function automatic plan_row_t reg_row(cfg_idx_t r, int v);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.reg_idx = r;
    row.reg_val = NPAGE_W'(v);
    return row;
  endfunction

  initial begin
    #200000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int ph, i, j, k, r, idx, n, off;
    logic [1:0] c;
    int vals [4];

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_ALLOC;
    in_page_index = '0;
    in_page_count = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_R0_FIRST;
    cfg_wdata = '0;
    row_typed = 1'b0;
    row_want = '0;
    idle_pct = 0;
    errors = 0;
    foreach (page_refs[p]) page_refs[p] = '0;
    free_pages = NPAGE_W'(STORE_PAGES);
    region_first[0] = '0;
    region_len[0] = NPAGE_W'(STORE_PAGES);
    region_first[1] = '0;
    region_len[1] = '0;

    plan = '{
      // rejections and zero-length ranges straight after reset
      checked_row(CMD_DEC, 0, 1, ST_UNDER, 0, 48'h0, 4096),
      checked_row(CMD_ALLOC, 0, 0, ST_RANGE, 0, 48'h0, 4096),
      checked_row(CMD_UNKNOWN, 4095, 8191, ST_RANGE, 0, 48'h0, 4096),
      checked_row(CMD_INC, 4095, 2, ST_RANGE, 0, 48'h0, 4096),
      checked_row(CMD_INC, 0, 0, ST_OK, 0, 48'h0, 4096),
      checked_row(CMD_DEC, 4095, 0, ST_OK, 0, 48'h0, 4096),
      // whole store in one run, then nothing left
      checked_row(CMD_ALLOC, 0, 4096, ST_OK, 0, 48'h100_0000, 0),
      checked_row(CMD_ALLOC, 0, 1, ST_NOMEM, 0, 48'h0, 0),
      cmd_row(CMD_INC, 0, 4096),
      cmd_row(CMD_DEC, 0, 4096),
      checked_row(CMD_DEC, 0, 4096, ST_OK, 0, 48'h0, 4096),
      checked_row(CMD_ALLOC, 2730, 3, ST_OK, 0, 48'h100_0000, 4093),
      checked_row(CMD_ALLOC, 0, 1, ST_OK, 3, 48'h100_3000, 4092),
      // a one-page hole too small for two pages
      cmd_row(CMD_DEC, 1, 1),
      cmd_row(CMD_ALLOC, 0, 2),
      cmd_row(CMD_ALLOC, 0, 1),
      cmd_row(CMD_DEC, 0, 7),
      cmd_row(CMD_DEC, 0, 6),
      // region 0 running past the end of the store, region 1 small
      reg_row(CFG_R0_FIRST, 4000),
      reg_row(CFG_R0_COUNT, 200),
      reg_row(CFG_R1_FIRST, 10),
      reg_row(CFG_R1_COUNT, 5),
      checked_row(CMD_ALLOC, 0, 96, ST_OK, 4000, 48'h1FA_0000, 4000),
      checked_row(CMD_ALLOC, 0, 5, ST_OK, 10, 48'h100_A000, 3995),
      checked_row(CMD_ALLOC, 0, 1, ST_NOMEM, 0, 48'h0, 3995),
      // empty region 0 is skipped
      reg_row(CFG_R0_FIRST, 0),
      reg_row(CFG_R0_COUNT, 0),
      reg_row(CFG_R1_FIRST, 20),
      checked_row(CMD_ALLOC, 0, 1, ST_OK, 20, 48'h101_4000, 3994),
      // overlapping regions
      reg_row(CFG_R0_COUNT, 12),
      reg_row(CFG_R1_FIRST, 5),
      reg_row(CFG_R1_COUNT, 4096),
      cmd_row(CMD_ALLOC, 0, 12),
      cmd_row(CMD_ALLOC, 0, 4)
    };

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue_command(plan[i].cmd, plan[i].idx, plan[i].n, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: vals = '{0, STORE_PAGES, 0, 0};
        1: vals = '{0, 256, 3840, STORE_PAGES};
        2: vals = '{4095, 1, $urandom_range(4095), $urandom_range(1, STORE_PAGES)};
        default: vals = '{$urandom_range(4095), $urandom_range(STORE_PAGES), 0, STORE_PAGES};
      endcase
      wait_idle();
      for (j = 0; j < 4; j++) write_reg(cfg_idx_t'(j), NPAGE_W'(vals[j]));
      // results cannot be held off, so only the command side idles
      idle_pct = (ph == 1) ? 51 : (ph == 3) ? 34 : 0;

      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          c = CMD_ALLOC;
          idx = $urandom_range(STORE_PAGES - 1);
          r = $urandom_range(99);
          n = (r < 80) ? $urandom_range(1, 8) :
              (r < 95) ? $urandom_range(9, 64) : $urandom_range(65, 600);
        end else if (r < 85 && live_base.size() != 0) begin
          // stay inside a run handed out earlier
          c = (r < 55) ? CMD_INC : CMD_DEC;
          k = $urandom_range(live_base.size() - 1);
          off = $urandom_range(live_len[k] - 1);
          idx = live_base[k] + off;
          n = $urandom_range(1, live_len[k] - off);
          if (c == CMD_DEC && off == 0 && n == live_len[k]) begin
            live_base.delete(k);
            live_len.delete(k);
          end
        end else begin
          c = 2'($urandom_range(3));
          idx = $urandom_range(STORE_PAGES - 1);
          n = $urandom_range(8191);
        end
        issue_command(c, PAGE_W'(idx), NPAGE_W'(n), 1'b0, '0);
      end
    end

    start = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (3 * STORE_PAGES) @(negedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: refcounted_page_allocator.f
hw/rtl/rcpa_pkg.sv
hw/rtl/rcpa_ram.sv
hw/rtl/refcounted_page_allocator.sv
sim/refcounted_page_allocator_tb.sv
